FILE: rtl/sqf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and control structs of the SOGI quadrature filter.
package sqf_pkg;

	localparam int OMEGA_W    = 24;
	localparam int PERIOD_W   = 32;
	localparam int GAIN_W     = 16;
	localparam int CFG_W      = 32;
	localparam int DELAY_W    = 48;
	localparam int DELAY_FRAC = 30;
	localparam int ACC_W      = 56;
	localparam int WTS_W      = 31;
	localparam int WIDE_W     = 64;
	localparam int MUL_A_W    = 49;
	localparam int MUL_B_W    = 32;
	localparam int MUL_DIGIT  = 8;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

	localparam logic [OMEGA_W-1:0]  OMEGA_FLOOR = 24'd8042;
	localparam logic [OMEGA_W-1:0]  OMEGA_TOL  = 24'd12;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd429497;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd23170;
	localparam logic [WIDE_W-1:0]   FOUR       = 64'h0004_0000_0000_0000;
	localparam logic [WTS_W-1:0]    WTS_MAX    = {WTS_W{1'b1}};

	localparam logic signed [ACC_W-1:0] DLY_MAX = ACC_W'({1'b0, {(DELAY_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] DLY_MIN = -DLY_MAX - ACC_W'(1);

	// Register indexes of the configuration port.
	localparam logic [0:0] CFG_PERIOD = 1'b0;
	localparam logic [0:0] CFG_GAIN   = 1'b1;

	typedef enum logic [3:0] {
		OP_WTS, OP_W2, OP_KW2, OP_B0, OP_A1, OP_A2, OP_LPQ, OP_BQ,
		OP_FB1, OP_FB2, OP_BP, OP_LP1, OP_LP2
	} op_t;

	typedef struct packed {
		logic load;
		logic start;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic redo;
	} stat_t;

	function automatic logic is_div(input op_t op);
		logic r;
		case (op)
			OP_B0, OP_A1, OP_A2, OP_LPQ: r = 1'b1;
			default:                     r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/sqf_mul.sv
`timescale 1ns / 1ps
// Iterative unsigned multiplier, one 8-bit digit of the second operand per cycle.
module sqf_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sqf_pkg::MUL_A_W-1:0] a,
	input  logic [sqf_pkg::MUL_B_W-1:0] b,
	output logic                        done,
	output logic [sqf_pkg::MUL_P_W-1:0] p
);
	localparam int AW = sqf_pkg::MUL_P_W - sqf_pkg::MUL_DIGIT;
	localparam int NDIG = sqf_pkg::MUL_B_W / sqf_pkg::MUL_DIGIT;
	localparam int CNTW = $clog2(NDIG);

	logic [AW-1:0]                a_q;
	logic [sqf_pkg::MUL_B_W-1:0]  b_q;
	logic [sqf_pkg::MUL_P_W-1:0]  p_q;
	logic [CNTW-1:0]              cnt_q;
	logic                         busy_q;
	logic                         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= AW'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= p_q + (sqf_pkg::MUL_P_W'(a_q) *
				sqf_pkg::MUL_P_W'(b_q[sqf_pkg::MUL_DIGIT-1:0]));
			a_q <= a_q << sqf_pkg::MUL_DIGIT;
			b_q <= b_q >> sqf_pkg::MUL_DIGIT;
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule

FILE: rtl/sqf_div.sv
`timescale 1ns / 1ps
// Restoring divider for fractions below two, one quotient bit per cycle, rounded half up.
module sqf_div #(
	parameter int FRAC = 30
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sqf_pkg::WIDE_W-1:0] n,
	input  logic [sqf_pkg::WIDE_W-1:0] d,
	output logic                       done,
	output logic [FRAC+1:0]            q
);
	localparam int CNTW = $clog2(FRAC + 1);

	logic [sqf_pkg::WIDE_W-1:0] r_q, d_q;
	logic [FRAC:0]              q_q;
	logic [CNTW-1:0]            cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       qbit;

	assign qbit = (r_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(FRAC)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= n;
			d_q <= d;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= (qbit ? (r_q - d_q) : r_q) << 1;
			q_q <= {q_q[FRAC-1:0], qbit};
		end
	end

	// The remainder left after the last step decides the rounding.
	assign q    = {1'b0, q_q} + (FRAC+2)'(qbit);
	assign done = done_q;
endmodule

FILE: rtl/sqf_dp.sv
`timescale 1ns / 1ps
// Datapath: registers, coefficients, delay line and the shared multiplier and divider.
module sqf_dp #(
	parameter int SB = 16,
	parameter int F  = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [sqf_pkg::CFG_W-1:0]    cfg_data,
	input  logic signed [SB-1:0]         in_sample,
	input  logic [sqf_pkg::OMEGA_W-1:0]  in_omega,
	input  sqf_pkg::cmd_t                cmd,
	output sqf_pkg::stat_t               stat,
	output logic signed [SB-1:0]         res_in_phase,
	output logic signed [SB-1:0]         res_quadrature,
	output logic                         res_recomputed
);
	localparam int CW = F + 2;
	localparam int YW = sqf_pkg::ACC_W - sqf_pkg::DELAY_FRAC;
	localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (SB - 1)) - 1);
	localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);
	localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

	// Configuration and persistent state.
	logic [sqf_pkg::PERIOD_W-1:0]        ts_q;
	logic [sqf_pkg::GAIN_W-1:0]          k_q;
	logic [sqf_pkg::OMEGA_W-1:0]         held_q;
	logic                                ok_q;
	logic signed [sqf_pkg::DELAY_W-1:0]  d1_q, d2_q;
	logic signed [CW-1:0]                b0_q, a1_q, a2_q, bq_q;

	// Working registers of one item.
	logic signed [SB-1:0]                smp_q;
	logic [sqf_pkg::OMEGA_W-1:0]         om_q;
	logic                                redo_q;
	logic [sqf_pkg::WTS_W-1:0]           wts_q;
	logic [sqf_pkg::WIDE_W-1:0]          w2_q, kw2_q, den_q;
	logic [CW-1:0]                       qt_q;
	logic signed [sqf_pkg::ACC_W-1:0]    acc_q;
	logic signed [sqf_pkg::DELAY_W-1:0]  w0_q;
	logic signed [SB-1:0]                va_q, vb_q;
	logic                                neg_q;
	logic signed [SB-1:0]                out_va_q, out_vb_q;
	logic                                out_redo_q;

	logic [sqf_pkg::OMEGA_W-1:0]         om_diff, om_clamp;
	logic                                redo_n;
	logic signed [sqf_pkg::MUL_A_W-1:0]  x_s;
	logic [sqf_pkg::MUL_A_W-1:0]         x_mag;
	logic signed [CW-1:0]                c_s;
	logic [CW-1:0]                       c_mag;
	logic [sqf_pkg::MUL_A_W-1:0]         mul_a;
	logic [sqf_pkg::MUL_B_W-1:0]         mul_b;
	logic                                mul_start, mul_done;
	logic [sqf_pkg::MUL_P_W-1:0]         mul_p;
	logic [sqf_pkg::WIDE_W-1:0]          div_n, pp;
	logic                                div_start, div_done;
	logic [CW-1:0]                       div_q;
	logic signed [sqf_pkg::ACC_W-1:0]    m_s, t_s, u_s, w_full;
	logic [sqf_pkg::MUL_P_W-1:0]         rnd_f, rnd_k, rnd_w;
	logic [40:0]                         wts_wide;

	function automatic logic signed [SB-1:0] to_sample(input logic signed [sqf_pkg::ACC_W-1:0] v);
		logic signed [sqf_pkg::ACC_W-1:0] x;
		logic signed [YW-1:0]             y;
		logic signed [SB-1:0]             r;
		x = v + sqf_pkg::ACC_W'(1 << (sqf_pkg::DELAY_FRAC - 1));
		y = YW'(x >>> sqf_pkg::DELAY_FRAC);
		if (y > Y_MAX)
			r = Y_MAX[SB-1:0];
		else if (y < Y_MIN)
			r = Y_MIN[SB-1:0];
		else
			r = y[SB-1:0];
		return r;
	endfunction

	function automatic logic signed [CW-1:0] pos_sat(input logic [CW-1:0] v);
		return (v > C_MAX) ? C_MAX : v;
	endfunction

	// Change test on the raw omega against the held, clamped value.
	assign om_diff  = (in_omega > held_q) ? (in_omega - held_q) : (held_q - in_omega);
	assign om_clamp = (in_omega < sqf_pkg::OMEGA_FLOOR) ? sqf_pkg::OMEGA_FLOOR : in_omega;
	assign redo_n   = !ok_q || (om_diff > sqf_pkg::OMEGA_TOL);

	always_comb begin
		case (cmd.op)
			sqf_pkg::OP_FB1: begin
				x_s = sqf_pkg::MUL_A_W'(d1_q);
				c_s = a1_q;
			end
			sqf_pkg::OP_FB2: begin
				x_s = sqf_pkg::MUL_A_W'(d2_q);
				c_s = a2_q;
			end
			sqf_pkg::OP_BP: begin
				x_s = sqf_pkg::MUL_A_W'(w0_q) - sqf_pkg::MUL_A_W'(d2_q);
				c_s = b0_q;
			end
			sqf_pkg::OP_LP1: begin
				x_s = sqf_pkg::MUL_A_W'(w0_q) + sqf_pkg::MUL_A_W'(d2_q);
				c_s = bq_q;
			end
			default: begin
				x_s = sqf_pkg::MUL_A_W'(d1_q);
				c_s = bq_q;
			end
		endcase
	end

	assign x_mag = x_s[sqf_pkg::MUL_A_W-1] ? (-x_s) : x_s;
	assign c_mag = c_s[CW-1] ? (-c_s) : c_s;

	always_comb begin
		case (cmd.op)
			sqf_pkg::OP_WTS: begin
				mul_a = sqf_pkg::MUL_A_W'(om_q);
				mul_b = ts_q;
			end
			sqf_pkg::OP_W2: begin
				mul_a = sqf_pkg::MUL_A_W'(wts_q);
				mul_b = sqf_pkg::MUL_B_W'(wts_q);
			end
			sqf_pkg::OP_KW2: begin
				mul_a = sqf_pkg::MUL_A_W'(wts_q);
				mul_b = sqf_pkg::MUL_B_W'(k_q);
			end
			sqf_pkg::OP_BQ: begin
				mul_a = sqf_pkg::MUL_A_W'(qt_q);
				mul_b = sqf_pkg::MUL_B_W'(k_q);
			end
			default: begin
				mul_a = x_mag;
				mul_b = sqf_pkg::MUL_B_W'(c_mag);
			end
		endcase
	end

	assign pp = sqf_pkg::FOUR + w2_q;

	always_comb begin
		case (cmd.op)
			sqf_pkg::OP_A1:
				div_n = (w2_q >= sqf_pkg::FOUR) ? ((w2_q - sqf_pkg::FOUR) << 1)
					: ((sqf_pkg::FOUR - w2_q) << 1);
			sqf_pkg::OP_A2:
				div_n = (pp >= kw2_q) ? (pp - kw2_q) : (kw2_q - pp);
			sqf_pkg::OP_LPQ:
				div_n = w2_q;
			default:
				div_n = kw2_q;
		endcase
	end

	assign div_start = cmd.start && sqf_pkg::is_div(cmd.op);
	assign mul_start = cmd.start && !sqf_pkg::is_div(cmd.op);

	sqf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	sqf_div #(.FRAC(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (den_q),
		.done   (div_done),
		.q      (div_q)
	);

	// Coefficient product: shift by F, nearest with ties away from zero.
	assign rnd_f  = (mul_p + (sqf_pkg::MUL_P_W'(1) << (F - 1))) >> F;
	assign m_s    = sqf_pkg::ACC_W'(rnd_f);
	assign t_s    = neg_q ? -m_s : m_s;
	assign rnd_k  = (mul_p + (sqf_pkg::MUL_P_W'(1) << 13)) >> 14;
	assign rnd_w  = (mul_p + (sqf_pkg::MUL_P_W'(1) << 15)) >> 16;
	assign wts_wide = rnd_w[40:0];
	assign u_s    = sqf_pkg::ACC_W'(smp_q) <<< sqf_pkg::DELAY_FRAC;
	assign w_full = acc_q - t_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q   <= sqf_pkg::PERIOD_RST;
			k_q    <= sqf_pkg::GAIN_RST;
			held_q <= '0;
			ok_q   <= 1'b0;
			d1_q   <= '0;
			d2_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sqf_pkg::CFG_PERIOD: begin
						ts_q <= cfg_data;
						ok_q <= 1'b0;
					end
					sqf_pkg::CFG_GAIN: begin
						k_q  <= cfg_data[sqf_pkg::GAIN_W-1:0];
						ok_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.load && redo_n) begin
				held_q <= om_clamp;
				ok_q   <= 1'b1;
			end
			if (mul_done && cmd.op == sqf_pkg::OP_LP2) begin
				d2_q <= d1_q;
				d1_q <= w0_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q  <= in_sample;
			om_q   <= om_clamp;
			redo_q <= redo_n;
		end
		if (mul_start)
			neg_q <= x_s[sqf_pkg::MUL_A_W-1] ^ c_s[CW-1];
		if (mul_done) begin
			case (cmd.op)
				sqf_pkg::OP_WTS:
					wts_q <= (wts_wide > 41'(sqf_pkg::WTS_MAX)) ? sqf_pkg::WTS_MAX
						: wts_wide[sqf_pkg::WTS_W-1:0];
				sqf_pkg::OP_W2:  w2_q <= mul_p[sqf_pkg::WIDE_W-1:0];
				sqf_pkg::OP_KW2: begin
					kw2_q <= mul_p[sqf_pkg::WIDE_W-1:0] << 11;
					den_q <= sqf_pkg::FOUR + (mul_p[sqf_pkg::WIDE_W-1:0] << 11) + w2_q;
				end
				sqf_pkg::OP_BQ:
					bq_q <= (rnd_k > sqf_pkg::MUL_P_W'(C_MAX)) ? C_MAX : rnd_k[CW-1:0];
				sqf_pkg::OP_FB1: acc_q <= u_s - t_s;
				sqf_pkg::OP_FB2: begin
					if (w_full > sqf_pkg::DLY_MAX)
						w0_q <= sqf_pkg::DLY_MAX[sqf_pkg::DELAY_W-1:0];
					else if (w_full < sqf_pkg::DLY_MIN)
						w0_q <= sqf_pkg::DLY_MIN[sqf_pkg::DELAY_W-1:0];
					else
						w0_q <= w_full[sqf_pkg::DELAY_W-1:0];
				end
				sqf_pkg::OP_BP:  va_q <= to_sample(t_s);
				sqf_pkg::OP_LP1: acc_q <= t_s;
				sqf_pkg::OP_LP2: vb_q <= to_sample(acc_q + (t_s <<< 1));
				default: ;
			endcase
		end
		if (div_done) begin
			case (cmd.op)
				sqf_pkg::OP_B0: b0_q <= pos_sat(div_q);
				sqf_pkg::OP_A1: a1_q <= (w2_q < sqf_pkg::FOUR) ? -div_q : pos_sat(div_q);
				sqf_pkg::OP_A2: a2_q <= (pp < kw2_q) ? -div_q : pos_sat(div_q);
				sqf_pkg::OP_LPQ: qt_q <= div_q;
				default: ;
			endcase
		end
		if (cmd.emit) begin
			out_va_q   <= va_q;
			out_vb_q   <= vb_q;
			out_redo_q <= redo_q;
		end
	end

	assign stat.done      = mul_done || div_done;
	assign stat.redo      = redo_q;
	assign res_in_phase   = out_va_q;
	assign res_quadrature = out_vb_q;
	assign res_recomputed = out_redo_q;
endmodule

FILE: rtl/sqf_ctrl.sv
`timescale 1ns / 1ps
// Controller: steps the datapath through coefficient update and filter operations.
module sqf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sqf_pkg::stat_t stat,
	output sqf_pkg::cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_FINISH
	} state_t;

	state_t         state_q;
	sqf_pkg::op_t   op_q;
	logic           out_valid_q;

	function automatic sqf_pkg::op_t next_op(input sqf_pkg::op_t op);
		sqf_pkg::op_t r;
		case (op)
			sqf_pkg::OP_WTS: r = sqf_pkg::OP_W2;
			sqf_pkg::OP_W2:  r = sqf_pkg::OP_KW2;
			sqf_pkg::OP_KW2: r = sqf_pkg::OP_B0;
			sqf_pkg::OP_B0:  r = sqf_pkg::OP_A1;
			sqf_pkg::OP_A1:  r = sqf_pkg::OP_A2;
			sqf_pkg::OP_A2:  r = sqf_pkg::OP_LPQ;
			sqf_pkg::OP_LPQ: r = sqf_pkg::OP_BQ;
			sqf_pkg::OP_BQ:  r = sqf_pkg::OP_FB1;
			sqf_pkg::OP_FB1: r = sqf_pkg::OP_FB2;
			sqf_pkg::OP_FB2: r = sqf_pkg::OP_BP;
			sqf_pkg::OP_BP:  r = sqf_pkg::OP_LP1;
			default:         r = sqf_pkg::OP_LP2;
		endcase
		return r;
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && in_ready;
	assign cmd.start = (state_q == S_ISSUE);
	assign cmd.emit  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign cmd.op    = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= sqf_pkg::OP_FB1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					op_q    <= stat.redo ? sqf_pkg::OP_WTS : sqf_pkg::OP_FB1;
					state_q <= S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.done) begin
						if (op_q == sqf_pkg::OP_LP2) begin
							state_q <= S_FINISH;
						end else begin
							op_q    <= next_op(op_q);
							state_q <= S_ISSUE;
						end
					end
				end
				S_FINISH: begin
					if (cmd.emit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/sogi_quadrature_filter.sv
`timescale 1ns / 1ps
// Top level of the SOGI quadrature filter: stream ports, controller and datapath.
//
// Each input word carries one signed sample and a tuning frequency omega in units of
// 1/256 rad/s; each output word carries the band-pass (in-phase) and low-pass
// (quadrature) filter outputs, rounded and saturated to SAMPLE_BITS, with tuser set
// when that sample caused the coefficients to be recomputed. The block works on one
// word at a time and keeps one finished result in an output register, so it takes the
// next word while the previous result is still waiting. A word whose coefficients are
// still valid takes five passes through the shared multiplier, which handles one
// 8-bit digit per cycle. A recomputation, triggered after reset, after any
// configuration write, or when omega moves more than 12 codes from the held value,
// adds four multiplier passes and four divisions. Omega below 10*pi rad/s is clamped
// before use. Configuration registers (index 0: sample period, unsigned Q0.32;
// index 1: gain k, unsigned Q2.14) are written through cfg_we and should only be
// written while idle.
module sogi_quadrature_filter #(
	parameter int SAMPLE_BITS     = 16,
	parameter int COEFF_FRAC_BITS = 30
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// sample, omega (from bit 0 up), zero padded to whole bytes
	input  logic [((SAMPLE_BITS+sqf_pkg::OMEGA_W+7)/8)*8-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// in_phase, quadrature (from bit 0 up), zero padded to whole bytes
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	// coeffs_recomputed
	output logic                     m_tuser,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [sqf_pkg::CFG_W-1:0] cfg_data
);
	localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

	sqf_pkg::cmd_t               cmd;
	sqf_pkg::stat_t              stat;
	logic signed [SAMPLE_BITS-1:0] res_in_phase, res_quadrature;

	sqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sqf_dp #(.SB(SAMPLE_BITS), .F(COEFF_FRAC_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_sample      (s_tdata[SAMPLE_BITS-1:0]),
		.in_omega       (s_tdata[SAMPLE_BITS+sqf_pkg::OMEGA_W-1:SAMPLE_BITS]),
		.cmd            (cmd),
		.stat           (stat),
		.res_in_phase   (res_in_phase),
		.res_quadrature (res_quadrature),
		.res_recomputed (m_tuser)
	);

	// Unused high bits of the output word are driven to zero.
	assign m_tdata = OUT_W'({res_quadrature, res_in_phase});
endmodule

FILE: rtl/sqf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the SOGI quadrature filter and their binding to the top level.
module sqf_port_props #(
	parameter int OUT_W = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);
	// A stalled output word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// Only one word is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// A new result appears only as the block returns to idle.
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result presented while still busy");
endmodule

bind sogi_quadrature_filter sqf_port_props #(.OUT_W(OUT_W)) u_sqf_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
